/* rtl/brr_pkg.sv */
// Package for the bilinear RGBA resizer: state, command and status types,
// register indexes, function codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brr_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_W     = 9;
    localparam int STEP_W     = 24;
    localparam int PIX_W      = 32;
    localparam int WGT_W      = 17;
    localparam int ACC_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP = 3'd5;

    localparam logic [SIZE_W-1:0] RST_SIZE = 9'd256;
    localparam logic [STEP_W-1:0] RST_STEP = 24'd65536;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_LOC,
        S_WGT,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_ACC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       mul;
        logic       loc;
        logic       wgt;
        logic       acc_clr;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       mac_en;
        logic [1:0] mac_sel;
        logic       res_load;
    } t_cmd;

    typedef struct packed {
        logic err;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/brr_ctrl.sv */
// Controller for the bilinear RGBA resizer: sequences one word through
// scale, locate, weight, four neighbor reads and the final blend.
// Out-of-range requests go from scale to finish. Depends on brr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brr_ctrl
    import brr_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   start,
    input  wire   i_func,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_func == FUNC_REQ) n_state = S_MUL;
            end
            S_MUL:  n_state = i_stat.err ? S_FIN : S_LOC;
            S_LOC:  n_state = S_WGT;
            S_WGT:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_ACC;
            S_ACC:  n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_LOC: o_cmd.loc = 1'b1;
            S_WGT: begin
                o_cmd.wgt     = 1'b1;
                o_cmd.acc_clr = 1'b1;
            end
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 2'd0;
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = 2'd1;
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sel = 2'd0;
            end
            S_RD2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = 2'd2;
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sel = 2'd1;
            end
            S_RD3: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = 2'd3;
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sel = 2'd2;
            end
            S_ACC: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sel = 2'd3;
            end
            S_FIN: o_cmd.res_load = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/brr_datapath.sv */
// Datapath for the bilinear RGBA resizer: config registers, pixel store,
// coordinate scaling, weights, per-channel blend and result register.
// Depends on brr_pkg; driven by brr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module brr_datapath
    import brr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_func,
    input  wire [7:0]             i_col,
    input  wire [7:0]             i_line,
    input  wire [PIX_W-1:0]       i_rgba_in,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [PIX_W-1:0]      o_rgba_out,
    output logic [7:0]            o_out_col,
    output logic [7:0]            o_out_line,
    output logic                  o_range_error,
    output logic                  o_valid
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);

    logic [SIZE_W-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [STEP_W-1:0] r_col_step, r_row_step;

    logic [PIX_W-1:0]  r_mem [DEPTH];
    logic [PIX_W-1:0]  r_rdata;

    logic [7:0]        r_col, r_line;
    logic              r_err;
    logic [31:0]       r_pos_x, r_pos_y;
    logic [XW-1:0]     r_x0, r_x1;
    logic [YW-1:0]     r_y0, r_y1;
    logic [7:0]        r_fx, r_fy;
    logic [WGT_W-1:0]  r_w00, r_w10, r_w01, r_w11;
    logic [ACC_W-1:0]  r_acc [4];
    logic              r_valid;

    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [XW-1:0]     rd_x;
    logic [YW-1:0]     rd_y;
    logic [15:0]       sw, sh, sw_m1, sh_m1;
    logic [15:0]       idx_x, idx_y;
    logic [XW-1:0]     n_x0, n_x1;
    logic [YW-1:0]     n_y0, n_y1;
    logic [8:0]        wx0, wy0;
    logic [WGT_W-1:0]  mac_w;
    logic [PIX_W-1:0]  blend;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= RST_SIZE;
            r_src_h    <= RST_SIZE;
            r_tgt_w    <= RST_SIZE;
            r_tgt_h    <= RST_SIZE;
            r_col_step <= RST_STEP;
            r_row_step <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_W:    r_src_w    <= i_cfg_data[SIZE_W-1:0];
                CFG_SRC_H:    r_src_h    <= i_cfg_data[SIZE_W-1:0];
                CFG_TGT_W:    r_tgt_w    <= i_cfg_data[SIZE_W-1:0];
                CFG_TGT_H:    r_tgt_h    <= i_cfg_data[SIZE_W-1:0];
                CFG_COL_STEP: r_col_step <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_STEP: r_row_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel store
    assign wr_ok = i_cmd.capture && i_func == FUNC_LOAD
                   && {8'd0, i_col} < 16'(MAX_WIDTH)
                   && {8'd0, i_line} < 16'(MAX_HEIGHT);
    assign wr_addr = AW'(i_line) * AW'(MAX_WIDTH) + AW'(i_col);

    always_comb begin
        case (i_cmd.rd_sel)
            2'd0: begin rd_x = r_x0; rd_y = r_y0; end
            2'd1: begin rd_x = r_x1; rd_y = r_y0; end
            2'd2: begin rd_x = r_x0; rd_y = r_y1; end
            default: begin rd_x = r_x1; rd_y = r_y1; end
        endcase
    end
    assign rd_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[wr_addr] <= i_rgba_in;
        if (i_cmd.rd_en) r_rdata <= r_mem[rd_addr];
    end

    // request capture and scaling
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col  <= i_col;
            r_line <= i_line;
            r_err  <= {1'b0, i_col} >= r_tgt_w || {1'b0, i_line} >= r_tgt_h;
        end
        if (i_cmd.mul) begin
            r_pos_x <= {24'd0, r_col} * {8'd0, r_col_step};
            r_pos_y <= {24'd0, r_line} * {8'd0, r_row_step};
        end
    end
    assign o_stat.err = r_err;

    // neighbor location with edge clamp
    always_comb begin
        sw = {7'd0, r_src_w};
        sh = {7'd0, r_src_h};
        if (sw == 16'd0) sw = 16'd1;
        else if (sw > 16'(MAX_WIDTH)) sw = 16'(MAX_WIDTH);
        if (sh == 16'd0) sh = 16'd1;
        else if (sh > 16'(MAX_HEIGHT)) sh = 16'(MAX_HEIGHT);
        sw_m1 = sw - 16'd1;
        sh_m1 = sh - 16'd1;
        idx_x = r_pos_x[31:16];
        idx_y = r_pos_y[31:16];
        if (idx_x >= sw_m1) begin
            n_x0 = sw_m1[XW-1:0];
            n_x1 = sw_m1[XW-1:0];
        end else begin
            n_x0 = idx_x[XW-1:0];
            n_x1 = idx_x[XW-1:0] + XW'(1);
        end
        if (idx_y >= sh_m1) begin
            n_y0 = sh_m1[YW-1:0];
            n_y1 = sh_m1[YW-1:0];
        end else begin
            n_y0 = idx_y[YW-1:0];
            n_y1 = idx_y[YW-1:0] + YW'(1);
        end
    end

    assign wx0 = 9'd256 - {1'b0, r_fx};
    assign wy0 = 9'd256 - {1'b0, r_fy};

    always_ff @(posedge i_clk) begin
        if (i_cmd.loc) begin
            r_x0 <= n_x0;
            r_x1 <= n_x1;
            r_y0 <= n_y0;
            r_y1 <= n_y1;
            r_fx <= r_pos_x[15:8];
            r_fy <= r_pos_y[15:8];
        end
        if (i_cmd.wgt) begin
            r_w00 <= WGT_W'({9'd0, wx0} * {9'd0, wy0});
            r_w10 <= WGT_W'({10'd0, r_fx} * {9'd0, wy0});
            r_w01 <= WGT_W'({9'd0, wx0} * {10'd0, r_fy});
            r_w11 <= WGT_W'({10'd0, r_fx} * {10'd0, r_fy});
        end
    end

    // per-channel multiply-accumulate
    always_comb begin
        case (i_cmd.mac_sel)
            2'd0:    mac_w = r_w00;
            2'd1:    mac_w = r_w10;
            2'd2:    mac_w = r_w01;
            default: mac_w = r_w11;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 4; ch++) begin
            if (i_cmd.acc_clr) begin
                r_acc[ch] <= '0;
            end else if (i_cmd.mac_en) begin
                r_acc[ch] <= r_acc[ch]
                    + ({16'd0, r_rdata[8*ch +: 8]} * {7'd0, mac_w});
            end
        end
    end

    // round half up, saturate
    always_comb begin
        logic [ACC_W:0] rnd;
        blend = '0;
        for (int ch = 0; ch < 4; ch++) begin
            rnd = {1'b0, r_acc[ch]} + (ACC_W+1)'(32768);
            blend[8*ch +: 8] = (rnd[ACC_W:16] > 9'd255) ? 8'hFF : rnd[23:16];
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_load;
        end
        if (i_cmd.res_load) begin
            o_rgba_out    <= r_err ? '0 : blend;
            o_out_col     <= r_col;
            o_out_line    <= r_line;
            o_range_error <= r_err;
        end
    end
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/bilinear_rgba_resize.sv */
// Bilinear RGBA8 resizer. Load: one word per cycle while idle, no result.
// Request: accepted while idle, passes MUL, LOC, WGT, RD0-RD3, ACC, FIN and
// then strobes the result (out of range: MUL to FIN); next word taken the
// cycle the result shows. Four neighbors are read one per cycle from the pixel store.
// Sync active-low reset clears control and config; the store is not cleared.
// Depends on brr_pkg, brr_ctrl, brr_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_rgba_resize
    import brr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   start,
    output logic                  busy,
    input  wire                   i_func,
    input  wire [7:0]             i_col,
    input  wire [7:0]             i_line,
    input  wire [PIX_W-1:0]       i_rgba_in,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_rgba_out,
    output logic [7:0]            o_out_col,
    output logic [7:0]            o_out_line,
    output logic                  o_range_error
);

    t_cmd  cmd;
    t_stat stat;

    brr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    brr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_col         (i_col),
        .i_line        (i_line),
        .i_rgba_in     (i_rgba_in),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_rgba_out    (o_rgba_out),
        .o_out_col     (o_out_col),
        .o_out_line    (o_out_line),
        .o_range_error (o_range_error),
        .o_valid       (o_valid)
    );

`ifndef SYNTHESIS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a request in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_rgba_out == '0))
        else $error("range error word carries nonzero pixel");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_REQ) |=> busy)
        else $error("request accepted but block not busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_LOAD) |=> (!busy && !o_valid))
        else $error("load word must not occupy the block or give a result");
`endif

endmodule

`default_nettype wire
